### hw/rtl/crbc_pkg.sv
// Package for the CSMA retry and backoff controller.
// Holds the state, action and radio status codes, the default register values
// and the request and response types of the serial modulo unit. Depends on nothing.
package crbc_pkg;

    localparam int SEQ_BITS_DEF = 16;
    localparam int RND_W        = 16;
    localparam int CNT_W        = 5;
    localparam int DIV_CNT_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    // Default register values.
    localparam logic [3:0]  MIN_BE_RST            = 4'd0;
    localparam logic [3:0]  MAX_BE_RST            = 4'd4;
    localparam logic [3:0]  MAX_BACKOFFS_RST      = 4'd5;
    localparam logic [3:0]  MAX_FRAME_RETRIES_RST = 4'd7;
    localparam logic [15:0] BACKOFF_TICKS_RST     = 16'd1;

    // Register indexes (byte address is 4 times the index).
    localparam logic [2:0] REG_MIN_BE            = 3'd0;
    localparam logic [2:0] REG_MAX_BE            = 3'd1;
    localparam logic [2:0] REG_MAX_BACKOFFS      = 3'd2;
    localparam logic [2:0] REG_MAX_FRAME_RETRIES = 3'd3;
    localparam logic [2:0] REG_BACKOFF_TICKS     = 3'd4;

    // Input modes.
    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    // Radio status codes.
    localparam logic [2:0] TX_OK        = 3'd0;
    localparam logic [2:0] TX_NOACK     = 3'd1;
    localparam logic [2:0] TX_COLLISION = 3'd2;
    localparam logic [2:0] TX_DEFERRED  = 3'd3;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_SCHEDULE = 2'd1,
        ACT_FINISH   = 2'd2
    } crbc_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV,
        ST_DONE
    } crbc_state_t;

    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [RND_W:0]   divisor;
    } crbc_div_req_t;

    typedef struct packed {
        logic             done;
        logic [RND_W-1:0] rem;
    } crbc_div_rsp_t;

endpackage

### hw/rtl/crbc_mod_serial.sv
// Bit-serial restoring modulo unit for the retry and backoff controller.
// Takes one dividend bit per cycle.
// Depends on crbc_pkg.
module crbc_mod_serial
    import crbc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  crbc_div_req_t req,
    output crbc_div_rsp_t rsp
);

    logic [RND_W-1:0]     shift_reg, shift_next;
    logic [RND_W-1:0]     rem_reg, rem_next;
    logic [RND_W:0]       divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RND_W:0]       trial;

    // Partial remainder never exceeds the dividend prefix, so 17 bits suffice.
    assign trial = {rem_reg, shift_reg[RND_W-1]};

    always_comb begin
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start) begin
            shift_next   = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[RND_W-2:0], 1'b0};
            if (trial >= divisor_reg) begin
                rem_next = RND_W'(trial - divisor_reg);
            end else begin
                rem_next = RND_W'(trial);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {DIV_CNT_W{1'b1}}) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg   <= shift_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### hw/rtl/csma_retry_backoff_controller.sv
// Top level of the CSMA retry and backoff controller.
// Holds the APB register file, frame counters, control sequencer and output register.
// Depends on crbc_pkg and crbc_mod_serial.
//
// Usage:
//   Input channel (s_valid/s_ready): one beat per submit or radio report.
//   A submit clears the frame counters, hands out a sequence number and
//   schedules the first transmission with zero delay. A report updates the
//   collision and attempt counters and either finishes the frame, ignores
//   the report (deferred), or schedules a retry after a random backoff.
//   Result channel (m_valid/m_ready): exactly one beat per input beat.
//   Beats that need no delay pass through ST_DONE into the output register; a retry
//   schedule first passes ST_WIN, which forms the backoff window and starts the
//   bit-serial modulo unit, and ST_DIV, which waits for its remainder. One item is
//   in work at a time: a new beat is accepted only after the last result is loaded.
//   A finished result waits in the output register while the next beat is
//   accepted; a stalled receiver only holds the block once a second result
//   is ready.
//   Reset (aresetn low, synchronous) clears counters, the sequence seed flag,
//   the state and m_valid, and loads the APB registers with their default values.
//   Configure through APB only while the block is idle.
module csma_retry_backoff_controller
    import crbc_pkg::*;
#(
    parameter int SEQ_BITS = SEQ_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [2:0]  s_tx_status,
    input  logic [3:0]  s_attempts_made,
    input  logic [15:0] s_random_word,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [15:0] m_delay_ticks,
    output logic [15:0] m_seq_number,
    output logic [2:0]  m_final_status,
    output logic [4:0]  m_attempt_count
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [3:0]  min_be_reg, max_be_reg, max_backoffs_reg, max_retries_reg;
    logic [15:0] backoff_ticks_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_be_reg        <= MIN_BE_RST;
            max_be_reg        <= MAX_BE_RST;
            max_backoffs_reg  <= MAX_BACKOFFS_RST;
            max_retries_reg   <= MAX_FRAME_RETRIES_RST;
            backoff_ticks_reg <= BACKOFF_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MIN_BE:            min_be_reg        <= pwdata[3:0];
                REG_MAX_BE:            max_be_reg        <= pwdata[3:0];
                REG_MAX_BACKOFFS:      max_backoffs_reg  <= pwdata[3:0];
                REG_MAX_FRAME_RETRIES: max_retries_reg   <= pwdata[3:0];
                REG_BACKOFF_TICKS:     backoff_ticks_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MIN_BE:            prdata = {28'd0, min_be_reg};
            REG_MAX_BE:            prdata = {28'd0, max_be_reg};
            REG_MAX_BACKOFFS:      prdata = {28'd0, max_backoffs_reg};
            REG_MAX_FRAME_RETRIES: prdata = {28'd0, max_retries_reg};
            REG_BACKOFF_TICKS:     prdata = {16'd0, backoff_ticks_reg};
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Frame state and per-item decision
    // ------------------------------------------------------------------
    crbc_state_t state_reg, state_next;

    logic [CNT_W-1:0]    coll_reg, coll_next;
    logic [CNT_W-1:0]    att_reg, att_next;
    logic [SEQ_BITS-1:0] nseq_reg, nseq_next;
    logic                seeded_reg, seeded_next;

    // Item result being built
    crbc_action_t        act_reg, act_next;
    logic [2:0]          fin_reg, fin_next;
    logic [SEQ_BITS-1:0] seqo_reg, seqo_next;
    logic [3:0]          be_reg, be_next;
    logic [RND_W-1:0]    rnd_reg;
    logic [RND_W-1:0]    delay_reg;
    logic                need_delay;

    logic                accept;
    logic [CNT_W:0]      coll_sum, att_sum, att_inc;
    logic [CNT_W-1:0]    coll_sat, att_sat, att_inc_sat;
    logic [SEQ_BITS-1:0] seq_pick;

    assign accept = s_valid && s_ready;

    assign coll_sum    = {1'b0, coll_reg} + {2'b00, s_attempts_made};
    assign att_sum     = {1'b0, att_reg} + {2'b00, s_attempts_made};
    assign att_inc     = {1'b0, att_reg} + 1'b1;
    assign coll_sat    = (coll_sum > {1'b0, CNT_MAX}) ? CNT_MAX : coll_sum[CNT_W-1:0];
    assign att_sat     = (att_sum > {1'b0, CNT_MAX}) ? CNT_MAX : att_sum[CNT_W-1:0];
    assign att_inc_sat = (att_inc > {1'b0, CNT_MAX}) ? CNT_MAX : att_inc[CNT_W-1:0];

    // Seed from the random word on the first submit; never issue zero.
    always_comb begin
        seq_pick = seeded_reg ? nseq_reg : s_random_word[SEQ_BITS-1:0];
        if (seq_pick == '0) begin
            seq_pick = SEQ_BITS'(1);
        end
    end

    always_comb begin
        coll_next   = coll_reg;
        att_next    = att_reg;
        nseq_next   = nseq_reg;
        seeded_next = seeded_reg;
        act_next    = act_reg;
        fin_next    = fin_reg;
        seqo_next   = seqo_reg;
        be_next     = be_reg;
        need_delay  = 1'b0;
        if (accept) begin
            act_next  = ACT_NONE;
            fin_next  = TX_OK;
            seqo_next = '0;
            if (s_mode == MODE_SUBMIT) begin
                coll_next   = '0;
                att_next    = '0;
                seeded_next = 1'b1;
                seqo_next   = seq_pick;
                nseq_next   = seq_pick + 1'b1;
                act_next    = ACT_SCHEDULE;
            end else begin
                priority case (s_tx_status)
                    TX_OK: begin
                        coll_next = {1'b0, min_be_reg};
                        att_next  = att_sat;
                        act_next  = ACT_FINISH;
                    end
                    TX_NOACK, TX_COLLISION: begin
                        if (s_tx_status == TX_NOACK) begin
                            coll_next = {1'b0, min_be_reg};
                            att_next  = att_sat;
                        end else if (coll_sat > {1'b0, max_backoffs_reg}) begin
                            coll_next = {1'b0, min_be_reg};
                            att_next  = att_inc_sat;
                        end else begin
                            coll_next = coll_sat;
                        end
                        if (att_next >= ({1'b0, max_retries_reg} + 1'b1)) begin
                            act_next = ACT_FINISH;
                            fin_next = s_tx_status;
                        end else begin
                            act_next   = ACT_SCHEDULE;
                            need_delay = 1'b1;
                        end
                    end
                    TX_DEFERRED: act_next = ACT_NONE;
                    default: begin
                        act_next = ACT_FINISH;
                        fin_next = s_tx_status;
                    end
                endcase
            end
            // Backoff exponent from the updated collision count
            be_next = (coll_next < {1'b0, max_be_reg}) ? coll_next[3:0] : max_be_reg;
        end
    end

    // ------------------------------------------------------------------
    // Backoff window: (2^be - 1) * unit = (unit << be) - unit
    // ------------------------------------------------------------------
    logic [15:0]    unit;
    logic [31:0]    window;
    logic           win_zero_reg;
    logic [RND_W:0] win_divisor;

    assign unit   = (backoff_ticks_reg == '0) ? 16'd1 : backoff_ticks_reg;
    assign window = ({16'd0, unit} << be_reg) - {16'd0, unit};
    // A window past 16 bits exceeds any random word: clamp so no subtract occurs.
    assign win_divisor = (|window[31:16]) ? {1'b1, 16'd0} : {1'b0, window[15:0]};

    crbc_div_req_t div_req;
    crbc_div_rsp_t div_rsp;
    logic          div_start;

    assign div_req.start    = div_start;
    assign div_req.dividend = rnd_reg;
    assign div_req.divisor  = win_divisor;

    crbc_mod_serial u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_free;
    logic out_load;

    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = need_delay ? ST_WIN : ST_DONE;
                end
            end
            ST_WIN:  state_next = ST_DIV;
            ST_DIV:  state_next = div_rsp.done ? ST_DONE : ST_DIV;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_WIN:  div_start = 1'b1;
            ST_DIV:  ;
            ST_DONE: out_load  = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            coll_reg   <= '0;
            att_reg    <= '0;
            nseq_reg   <= '0;
            seeded_reg <= 1'b0;
            act_reg    <= ACT_NONE;
        end else begin
            state_reg  <= state_next;
            coll_reg   <= coll_next;
            att_reg    <= att_next;
            nseq_reg   <= nseq_next;
            seeded_reg <= seeded_next;
            act_reg    <= act_next;
        end
        fin_reg  <= fin_next;
        seqo_reg <= seqo_next;
        be_reg   <= be_next;
        if (accept) begin
            rnd_reg   <= s_random_word;
            delay_reg <= '0;
        end
        if (state_reg == ST_WIN) begin
            win_zero_reg <= (window == '0);
        end
        // Capture the remainder; a zero window gives zero delay
        if (state_reg == ST_DIV && div_rsp.done) begin
            delay_reg <= win_zero_reg ? '0 : div_rsp.rem;
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the receiver takes the beat
    // ------------------------------------------------------------------
    logic              m_valid_reg;
    logic [1:0]        m_action_reg;
    logic [15:0]       m_delay_reg, m_seq_reg;
    logic [2:0]        m_fin_reg;
    logic [CNT_W-1:0]  m_att_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_action_reg <= act_reg;
            m_delay_reg  <= delay_reg;
            m_seq_reg    <= 16'(seqo_reg);
            m_fin_reg    <= fin_reg;
            m_att_reg    <= att_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_action        = m_action_reg;
    assign m_delay_ticks   = m_delay_reg;
    assign m_seq_number    = m_seq_reg;
    assign m_final_status  = m_fin_reg;
    assign m_attempt_count = m_att_reg;

endmodule
